// File: rtl/core/mtp_pkg.sv
// Shared constants and types for the MT19937 generator.
`timescale 1ns / 1ps
package mtp_pkg;
  localparam int Words = 624;
  localparam int Shift = 397;
  localparam int AddrW = 10;
  localparam logic [31:0] InitMult = 32'd1812433253;
  localparam logic [31:0] Matrix   = 32'h9908B0DF;
  localparam logic [31:0] TemperB  = 32'h9D2C5680;
  localparam logic [31:0] TemperC  = 32'hEFC60000;
  localparam int TryLimit = 64;

  localparam logic [1:0] CMD_SEED    = 2'd0;
  localparam logic [1:0] CMD_RAW     = 2'd1;
  localparam logic [1:0] CMD_UNIFORM = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [1:0]  cmd;
    logic [31:0] operand;
  } q_head_t;
endpackage

// File: rtl/core/mersenne_twister_prng.sv
// MT19937 generator: a raw draw is returned after its input transaction, and waits for a
// regeneration of the 624-word state when that state is used up (three RAM accesses per word).
// A seed occupies the back end for one 32x32 multiply and one write per word.
// A bounded draw runs two modulos in the bit-serial divider plus its raw
// draws, with one more raw draw per extra try. Sync reset, active low;
// the store reads as zero until the first seed, and no clearing pass is needed.
`timescale 1ns / 1ps
module mersenne_twister_prng (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_value
);
  mtp_pkg::q_head_t head;
  logic             pop;

  mtp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_operand (in_operand),
    .head       (head),
    .pop        (pop)
  );

  mtp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );
endmodule

// File: rtl/core/mtp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mtp_ram #(
  parameter int Width = 32,
  parameter int Depth = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// File: rtl/core/mtp_front.sv
// Front end: accepts commands, drops the CMD_NONE code, two-entry queue to the back end.
`timescale 1ns / 1ps
module mtp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [31:0]          in_operand,
  output mtp_pkg::q_head_t     head,
  input  logic                 pop
);
  logic [1:0]  cmd_r [2];
  logic [31:0] opd_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, do_pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && (in_command != mtp_pkg::CMD_NONE);
  assign do_pop   = pop && (cnt_r != 2'd0);

  assign head.valid   = (cnt_r != 2'd0);
  assign head.cmd     = cmd_r[0];
  assign head.operand = opd_r[0];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // a push that lands in the head slot takes precedence over the shift
  always_ff @(posedge clk) begin
    if (push && (cnt_nxt == 2'd1)) begin
      cmd_r[0] <= in_command;
      opd_r[0] <= in_operand;
    end else if (do_pop) begin
      cmd_r[0] <= cmd_r[1];
      opd_r[0] <= opd_r[1];
    end
    if (push && (cnt_nxt != 2'd1)) begin
      cmd_r[1] <= in_command;
      opd_r[1] <= in_operand;
    end
  end
endmodule

// File: rtl/core/mtp_divider.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module mtp_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] remainder
);
  logic [31:0] num_r, den_r, rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial;

  assign trial     = {rem_r, num_r[31]};
  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= 32'd0;
    end else if (busy_r) begin
      num_r <= {num_r[30:0], 1'b0};
      if (trial >= {1'b0, den_r}) rem_r <= 32'(trial - {1'b0, den_r});
      else rem_r <= trial[31:0];
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r)) else $error("done without a run");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
`endif
endmodule

// File: rtl/core/mtp_back.sv
// Back end: seeding, state regeneration, tempering and bounded draws.
`timescale 1ns / 1ps
module mtp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtp_pkg::q_head_t     head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_random_value
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SEEDMUL = 4'd1;
  localparam logic [3:0] S_SEEDWR  = 4'd2;
  localparam logic [3:0] S_TWP     = 4'd3;
  localparam logic [3:0] S_TWQ     = 4'd4;
  localparam logic [3:0] S_TWA     = 4'd5;
  localparam logic [3:0] S_TWB     = 4'd6;
  localparam logic [3:0] S_TWC     = 4'd7;
  localparam logic [3:0] S_DRAW    = 4'd8;
  localparam logic [3:0] S_TEMPER  = 4'd9;
  localparam logic [3:0] S_MODM    = 4'd10;
  localparam logic [3:0] S_MODR    = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  localparam int AW = mtp_pkg::AddrW;
  localparam logic [AW-1:0] LastIdx = AW'(mtp_pkg::Words - 1);
  localparam logic [AW-1:0] WordsA  = AW'(mtp_pkg::Words);
  localparam logic [AW-1:0] SplitA  = AW'(mtp_pkg::Words - mtp_pkg::Shift);
  localparam logic [AW-1:0] ShiftA  = AW'(mtp_pkg::Shift);
  localparam logic [5:0]    LastTry = 6'(mtp_pkg::TryLimit - 1);

  logic [3:0]    state_r;
  logic [AW-1:0] pos_r, idx_r;
  logic          seeded_r, uni_r, cur_hi_r;
  logic [31:0]   v_r, prod_r, nxt_r, bound_r, m_r, res_r, out_data_r;
  logic [5:0]    tries_r;
  logic          out_valid_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr, j_idx, k_idx;
  logic [31:0]   wr_data, rd_data, rdm, x, y, tempered, seed_word;
  logic          div_start, div_busy, div_done;
  logic [31:0]   div_a, div_b, div_rem;
  logic          uni_take;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & mtp_pkg::TemperB);
    t = t ^ ((t << 15) & mtp_pkg::TemperC);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // never-seeded store reads as all zero
  assign rdm       = seeded_r ? rd_data : 32'd0;
  assign j_idx     = (idx_r == LastIdx) ? '0 : idx_r + AW'(1);
  assign k_idx     = (idx_r < SplitA) ? idx_r + ShiftA : idx_r - SplitA;
  assign x         = {cur_hi_r, nxt_r[30:0]};
  assign y         = (x >> 1) ^ (x[0] ? mtp_pkg::Matrix : 32'd0);
  assign tempered  = temper(rdm);
  assign seed_word = prod_r + {{(32-AW){1'b0}}, idx_r};
  assign uni_take  = (tempered >= m_r) || (tries_r == LastTry);

  assign pop = (state_r == S_IDLE) && head.valid;
  assign out_valid = out_valid_r;
  assign out_random_value = out_data_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rdm ^ y;
    rd_addr = pos_r;
    case (state_r)
      S_IDLE: begin
        wr_en   = head.valid && (head.cmd == mtp_pkg::CMD_SEED);
        wr_addr = '0;
        wr_data = head.operand;
      end
      S_SEEDWR: begin
        wr_en   = 1'b1;
        wr_data = seed_word;
      end
      S_TWP:   rd_addr = '0;
      S_TWA:   rd_addr = j_idx;
      S_TWB:   rd_addr = k_idx;
      S_TWC:   wr_en   = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = 32'd0 - head.operand;
    div_b     = head.operand;
    if (state_r == S_IDLE && head.valid && head.cmd == mtp_pkg::CMD_UNIFORM &&
        head.operand > 32'd1) begin
      div_start = 1'b1;
    end else if (state_r == S_TEMPER && uni_r && uni_take) begin
      div_start = 1'b1;
      div_a     = tempered;
      div_b     = bound_r;
    end
  end

  mtp_ram #(.Width(32), .Depth(mtp_pkg::Words)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mtp_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // S_FIN owns the output register in its own arm
      if (out_valid_r && out_ready && (state_r != S_FIN)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            bound_r <= head.operand;
            tries_r <= 6'd0;
            case (head.cmd)
              mtp_pkg::CMD_SEED: begin
                v_r      <= head.operand;
                idx_r    <= AW'(1);
                seeded_r <= 1'b1;
                state_r  <= S_SEEDMUL;
              end
              mtp_pkg::CMD_RAW: begin
                uni_r   <= 1'b0;
                state_r <= S_DRAW;
              end
              default: begin
                uni_r <= 1'b1;
                if (head.operand > 32'd1) begin
                  state_r <= S_MODM;
                end else begin
                  res_r   <= 32'd0;
                  state_r <= S_FIN;
                end
              end
            endcase
          end
        end
        S_SEEDMUL: begin
          prod_r  <= 32'((v_r ^ (v_r >> 30)) * mtp_pkg::InitMult);
          state_r <= S_SEEDWR;
        end
        S_SEEDWR: begin
          v_r <= seed_word;
          if (idx_r == LastIdx) begin
            pos_r   <= WordsA;
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_SEEDMUL;
          end
        end
        S_TWP: state_r <= S_TWQ;
        S_TWQ: begin
          cur_hi_r <= rdm[31];
          state_r  <= S_TWA;
        end
        S_TWA: state_r <= S_TWB;
        S_TWB: begin
          nxt_r   <= rdm;
          state_r <= S_TWC;
        end
        S_TWC: begin
          cur_hi_r <= nxt_r[31];
          if (idx_r == LastIdx) begin
            state_r <= S_DRAW;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_TWA;
          end
        end
        S_DRAW: begin
          if (pos_r >= WordsA) begin
            pos_r   <= '0;
            idx_r   <= '0;
            state_r <= S_TWP;
          end else begin
            state_r <= S_TEMPER;
          end
        end
        S_TEMPER: begin
          pos_r <= pos_r + AW'(1);
          if (!uni_r) begin
            res_r   <= tempered;
            state_r <= S_FIN;
          end else if (uni_take) begin
            state_r <= S_MODR;
          end else begin
            tries_r <= tries_r + 6'd1;
            state_r <= S_DRAW;
          end
        end
        S_MODM: begin
          if (div_done) begin
            m_r     <= div_rem;
            state_r <= S_DRAW;
          end
        end
        S_MODR: begin
          if (div_done) begin
            res_r   <= div_rem;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= WordsA) else $error("read position beyond store");
  a_wr_states: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_IDLE || state_r == S_SEEDWR || state_r == S_TWC))
    else $error("store write outside seed or twist");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MODM || state_r == S_MODR) && !div_done |-> div_busy)
    else $error("waiting on idle divider");
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_valid_r && !out_ready |=> state_r == S_FIN)
    else $error("result dropped while output stalled");
`endif
endmodule
